FILE: hw/rtl/ilmq_pkg.sv
// Package for the indexed linked message queue.
// Holds sizes, mode codes and the structs shared by the store, the sequencer and the top.
// Depends on nothing.
package ilmq_pkg;

   localparam int NUM_ENTRIES = 64;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int PTR_W       = IDX_W + 1;
   localparam int MODE_W      = 2;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [MODE_W-1:0] mode_type;

   localparam ptr_type NONE = ptr_type'(NUM_ENTRIES);

   localparam mode_type MODE_ENQ       = 2'd0;
   localparam mode_type MODE_REMOVE    = 2'd1;
   localparam mode_type MODE_FIND_SEND = 2'd2;
   localparam mode_type MODE_FIND_RECV = 2'd3;

   typedef struct packed {
      logic    clear_links;
      logic    prev_we;
      idx_type prev_addr;
      ptr_type prev_data;
      logic    next_we;
      idx_type next_addr;
      ptr_type next_data;
      logic    recv_we;
      idx_type recv_addr;
      ptr_type recv_data;
   } store_wr_type;

   typedef struct packed {
      ptr_type prev;
      ptr_type next;
      ptr_type recv;
   } store_rd_type;

   typedef struct packed {
      logic    found;
      ptr_type sender_id;
   } result_type;

endpackage

FILE: hw/rtl/ilmq_store.sv
// Link and receiver storage: prev, next and receiver arrays with per-entry valid bits.
// One read address shared by all three arrays, with registered read data; depends on ilmq_pkg.
module ilmq_store (
   input  logic                  clock,
   input  logic                  reset,
   input  ilmq_pkg::idx_type     rd_addr,
   input  ilmq_pkg::store_wr_type wr,
   output ilmq_pkg::store_rd_type rd
);

   ilmq_pkg::ptr_type prev_mem [ilmq_pkg::NUM_ENTRIES];
   ilmq_pkg::ptr_type next_mem [ilmq_pkg::NUM_ENTRIES];
   ilmq_pkg::ptr_type recv_mem [ilmq_pkg::NUM_ENTRIES];

   logic [ilmq_pkg::NUM_ENTRIES-1:0] prev_vld_ff, prev_vld_in;
   logic [ilmq_pkg::NUM_ENTRIES-1:0] next_vld_ff, next_vld_in;
   logic [ilmq_pkg::NUM_ENTRIES-1:0] recv_vld_ff, recv_vld_in;

   ilmq_pkg::ptr_type prev_raw_ff, next_raw_ff, recv_raw_ff;
   logic              prev_hit_ff, next_hit_ff, recv_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.prev_we) begin
         prev_mem[wr.prev_addr] <= wr.prev_data;
      end
      if (wr.next_we) begin
         next_mem[wr.next_addr] <= wr.next_data;
      end
      if (wr.recv_we) begin
         recv_mem[wr.recv_addr] <= wr.recv_data;
      end
      prev_raw_ff <= prev_mem[rd_addr];
      next_raw_ff <= next_mem[rd_addr];
      recv_raw_ff <= recv_mem[rd_addr];
   end

   // clearing the links drops the prev and next valid bits; an invalid entry reads as none
   always_comb begin
      prev_vld_in = prev_vld_ff;
      next_vld_in = next_vld_ff;
      recv_vld_in = recv_vld_ff;
      if (wr.clear_links) begin
         prev_vld_in = '0;
         next_vld_in = '0;
      end
      if (wr.prev_we) begin
         prev_vld_in[wr.prev_addr] = 1'b1;
      end
      if (wr.next_we) begin
         next_vld_in[wr.next_addr] = 1'b1;
      end
      if (wr.recv_we) begin
         recv_vld_in[wr.recv_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_vld_ff <= '0;
         next_vld_ff <= '0;
         recv_vld_ff <= '0;
         prev_hit_ff <= 1'b0;
         next_hit_ff <= 1'b0;
         recv_hit_ff <= 1'b0;
      end else begin
         prev_vld_ff <= prev_vld_in;
         next_vld_ff <= next_vld_in;
         recv_vld_ff <= recv_vld_in;
         prev_hit_ff <= prev_vld_ff[rd_addr];
         next_hit_ff <= next_vld_ff[rd_addr];
         recv_hit_ff <= recv_vld_ff[rd_addr];
      end
   end

   assign rd.prev = prev_hit_ff ? prev_raw_ff : ilmq_pkg::NONE;
   assign rd.next = next_hit_ff ? next_raw_ff : ilmq_pkg::NONE;
   assign rd.recv = recv_hit_ff ? recv_raw_ff : ilmq_pkg::NONE;

endmodule

FILE: hw/rtl/ilmq_seq.sv
// Sequencer: enqueue, remove and list walk over the shared store, one store read a cycle.
// Keeps head and tail; depends on ilmq_pkg and drives ilmq_store.
module ilmq_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  ilmq_pkg::mode_type     in_mode,
   input  ilmq_pkg::idx_type      in_id,
   input  ilmq_pkg::ptr_type      in_receiver,
   output logic                   in_ready,
   input  logic                   out_free,
   output logic                   res_valid,
   output ilmq_pkg::result_type   res,
   output ilmq_pkg::idx_type      rd_addr,
   output ilmq_pkg::store_wr_type wr,
   input  ilmq_pkg::store_rd_type rd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ENQ_CHK  = 3'd1;
   localparam logic [2:0] S_ENQ_LINK = 3'd2;
   localparam logic [2:0] S_REM_CHK  = 3'd3;
   localparam logic [2:0] S_REM_CLR  = 3'd4;
   localparam logic [2:0] S_WALK     = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]         state_ff, state_in;
   ilmq_pkg::mode_type mode_ff, mode_in;
   ilmq_pkg::idx_type  key_ff, key_in;
   ilmq_pkg::ptr_type  recv_ff, recv_in;
   ilmq_pkg::ptr_type  head_ff, head_in;
   ilmq_pkg::ptr_type  tail_ff, tail_in;
   ilmq_pkg::idx_type  cur_ff, cur_in;
   ilmq_pkg::idx_type  step_ff, step_in;
   logic               found_ff, found_in;
   ilmq_pkg::ptr_type  hit_ff, hit_in;

   ilmq_pkg::ptr_type  key_ptr;
   logic               queued;
   logic               match;

   assign key_ptr = ilmq_pkg::ptr_type'(key_ff);
   assign queued  = (rd.prev != ilmq_pkg::NONE) || (rd.next != ilmq_pkg::NONE) ||
                    (head_ff == key_ptr);
   assign match   = (mode_ff == ilmq_pkg::MODE_FIND_RECV) ? (rd.recv == key_ptr)
                                                          : (cur_ff == key_ff);

   assign in_ready      = (state_ff == S_IDLE);
   assign res_valid     = (state_ff == S_DONE);
   assign res.found     = found_ff;
   assign res.sender_id = hit_ff;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      key_in   = key_ff;
      recv_in  = recv_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cur_in   = cur_ff;
      step_in  = step_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      rd_addr  = key_ff;
      wr       = '0;

      case (state_ff)
         S_IDLE: begin
            if (in_mode == ilmq_pkg::MODE_FIND_SEND || in_mode == ilmq_pkg::MODE_FIND_RECV) begin
               rd_addr = head_ff[ilmq_pkg::IDX_W-1:0];
            end else begin
               rd_addr = in_id;
            end
            if (in_accept) begin
               mode_in  = in_mode;
               key_in   = in_id;
               recv_in  = (in_receiver >= ilmq_pkg::NONE) ? ilmq_pkg::NONE : in_receiver;
               found_in = 1'b0;
               hit_in   = ilmq_pkg::NONE;
               cur_in   = head_ff[ilmq_pkg::IDX_W-1:0];
               step_in  = '0;
               case (in_mode)
                  ilmq_pkg::MODE_ENQ:    state_in = S_ENQ_CHK;
                  ilmq_pkg::MODE_REMOVE: state_in = S_REM_CHK;
                  default: begin
                     state_in = (head_ff == ilmq_pkg::NONE) ? S_DONE : S_WALK;
                  end
               endcase
            end
         end
         S_ENQ_CHK: begin
            wr.recv_we   = 1'b1;
            wr.recv_addr = key_ff;
            wr.recv_data = recv_ff;
            if (queued) begin
               state_in = S_DONE;
            end else begin
               wr.prev_we   = 1'b1;
               wr.prev_addr = key_ff;
               wr.prev_data = tail_ff;
               wr.next_we   = 1'b1;
               wr.next_addr = key_ff;
               wr.next_data = ilmq_pkg::NONE;
               if (tail_ff == ilmq_pkg::NONE) begin
                  head_in  = key_ptr;
                  tail_in  = key_ptr;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ENQ_LINK;
               end
            end
         end
         S_ENQ_LINK: begin
            wr.next_we   = 1'b1;
            wr.next_addr = tail_ff[ilmq_pkg::IDX_W-1:0];
            wr.next_data = key_ptr;
            tail_in      = key_ptr;
            state_in     = S_DONE;
         end
         S_REM_CHK: begin
            if (rd.prev == ilmq_pkg::NONE && rd.next == ilmq_pkg::NONE) begin
               // lone head or not queued: the queue empties
               wr.clear_links = 1'b1;
               head_in        = ilmq_pkg::NONE;
               tail_in        = ilmq_pkg::NONE;
               state_in       = S_DONE;
            end else begin
               if (rd.prev == ilmq_pkg::NONE) begin
                  head_in = rd.next;
               end else begin
                  wr.next_we   = 1'b1;
                  wr.next_addr = rd.prev[ilmq_pkg::IDX_W-1:0];
                  wr.next_data = rd.next;
               end
               if (rd.next == ilmq_pkg::NONE) begin
                  tail_in = rd.prev;
               end else begin
                  wr.prev_we   = 1'b1;
                  wr.prev_addr = rd.next[ilmq_pkg::IDX_W-1:0];
                  wr.prev_data = rd.prev;
               end
               state_in = S_REM_CLR;
            end
         end
         S_REM_CLR: begin
            wr.prev_we   = 1'b1;
            wr.prev_addr = key_ff;
            wr.prev_data = ilmq_pkg::NONE;
            wr.next_we   = 1'b1;
            wr.next_addr = key_ff;
            wr.next_data = ilmq_pkg::NONE;
            state_in     = S_DONE;
         end
         S_WALK: begin
            // rd holds the entry at cur; the next entry is fetched meanwhile
            rd_addr = rd.next[ilmq_pkg::IDX_W-1:0];
            if (match) begin
               found_in = 1'b1;
               hit_in   = ilmq_pkg::ptr_type'(cur_ff);
               state_in = S_DONE;
            end else if (rd.next == ilmq_pkg::NONE ||
                         step_ff == ilmq_pkg::idx_type'(ilmq_pkg::NUM_ENTRIES - 1)) begin
               state_in = S_DONE;
            end else begin
               cur_in  = rd.next[ilmq_pkg::IDX_W-1:0];
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= ilmq_pkg::NONE;
         tail_ff  <= ilmq_pkg::NONE;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      recv_ff  <= recv_in;
      cur_ff   <= cur_in;
      step_ff  <= step_in;
      found_ff <= found_in;
      hit_ff   <= hit_in;
   end

endmodule

FILE: hw/rtl/indexed_linked_message_queue.sv
// Top level of the indexed linked message queue: stream ports and the result register.
// Depends on ilmq_pkg, ilmq_store and ilmq_seq.
//
// Keeps a FIFO of pending senders as a doubly linked list over 64 sender ids. Each request
// beat gives exactly one response beat. Enqueue passes a check state, a link state if the id
// is new and the queue not empty, and a done state; remove a check state, a clear state unless
// the queue empties, and done; a search walks at most 64 entries, reading one entry a cycle
// through the single read port of the link store. The block takes no request while one is in
// progress; a finished response waits in its own register, so the next request may be
// accepted before it is taken. Sender ids are returned on 7 bits, with 64 meaning none.
// Removing a sender that is not queued, or the only queued sender, empties the queue.
module indexed_linked_message_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // mode[1:0], id[7:2], receiver[14:8], zero[15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // found[0], sender_id[7:1]
);

   logic                   in_accept;
   logic                   out_free;
   logic                   res_valid;
   ilmq_pkg::result_type   res;
   ilmq_pkg::idx_type      rd_addr;
   ilmq_pkg::store_wr_type wr;
   ilmq_pkg::store_rd_type rd;

   logic                   rsp_valid_ff;
   ilmq_pkg::result_type   rsp_data_ff;

   assign in_accept = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   ilmq_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd      (rd)
   );

   ilmq_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (in_accept),
      .in_mode     (req_tdata[1:0]),
      .in_id       (req_tdata[7:2]),
      .in_receiver (req_tdata[14:8]),
      .in_ready    (req_tready),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .rd_addr     (rd_addr),
      .wr          (wr),
      .rd          (rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.sender_id, rsp_data_ff.found};

endmodule

FILE: tb/tb.sv
// Testbench for indexed_linked_message_queue: directed, full-walk, back-pressure and random beats.
// Keeps its own linked-list model of the queue and checks every response beat in order.
// Depends on ilmq_pkg and the RTL top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ilmq_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // mode[1:0], id[7:2], receiver[14:8], zero[15]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // found[0], sender_id[7:1]

   indexed_linked_message_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4ns clock = ~clock;

   // queue model
   ptr_type    mdl_prev [0:NUM_ENTRIES-1];
   ptr_type    mdl_next [0:NUM_ENTRIES-1];
   ptr_type    mdl_recv [0:NUM_ENTRIES-1];
   ptr_type    mdl_head;
   ptr_type    mdl_tail;
   idx_type    live_ids [$];

   result_type pending_rsp [$];
   int         errors = 0;

   // sender and receiver pacing
   int tx_gap_max   = 0;
   int rx_stall_max = 0;
   int idle_cycles  = 0;
   int burst_left   = 0;
   int hold_len     = 0;
   int hold_token   = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int rx_run       = 0;
   logic rx_ready_now = 1'b1;

   function automatic void clear_model_links();
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         mdl_prev[k] = NONE;
         mdl_next[k] = NONE;
      end
      mdl_head = NONE;
      mdl_tail = NONE;
   endfunction

   function automatic result_type predict_queue_op(mode_type m, idx_type i, ptr_type r);
      result_type res;
      ptr_type    p, n, cur;
      ptr_type    key;
      logic       hit;
      int         steps;
      res.found     = 1'b0;
      res.sender_id = NONE;
      key           = ptr_type'(i);
      case (m)
         MODE_ENQ: begin
            mdl_recv[i] = (r >= NONE) ? NONE : r;
            if (mdl_prev[i] == NONE && mdl_next[i] == NONE && mdl_head != key) begin
               if (mdl_tail == NONE) begin
                  mdl_head = key;
               end else begin
                  mdl_next[mdl_tail] = key;
               end
               mdl_prev[i] = mdl_tail;
               mdl_next[i] = NONE;
               mdl_tail    = key;
            end
         end
         MODE_REMOVE: begin
            p = mdl_prev[i];
            n = mdl_next[i];
            if (p == NONE && n == NONE) begin
               clear_model_links();
            end else begin
               if (p == NONE) begin
                  mdl_head    = n;
                  mdl_prev[n] = NONE;
               end else if (n == NONE) begin
                  mdl_tail    = p;
                  mdl_next[p] = NONE;
               end else begin
                  mdl_next[p] = n;
                  mdl_prev[n] = p;
               end
               mdl_prev[i] = NONE;
               mdl_next[i] = NONE;
            end
         end
         default: begin
            cur = mdl_head;
            hit = 1'b0;
            for (steps = 0; steps < NUM_ENTRIES && cur < NONE && !hit; steps++) begin
               if (m == MODE_FIND_RECV ? (mdl_recv[cur] == key) : (cur == key)) begin
                  hit           = 1'b1;
                  res.found     = 1'b1;
                  res.sender_id = cur;
               end else begin
                  cur = mdl_next[cur];
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic void refresh_live();
      ptr_type cur;
      live_ids.delete();
      cur = mdl_head;
      for (int k = 0; k < NUM_ENTRIES && cur < NONE; k++) begin
         live_ids.push_back(cur[IDX_W-1:0]);
         cur = mdl_next[cur];
      end
   endfunction

   // small pool for receiver collisions, plus the none value and values above it
   function automatic ptr_type pick_receiver();
      int pct;
      pct = $urandom_range(0, 99);
      if (pct < 60)
         return ptr_type'($urandom_range(0, 15));
      else if (pct < 85)
         return ptr_type'($urandom_range(0, 64));
      else
         return ptr_type'($urandom_range(65, 127));
   endfunction

   task automatic send_op(input mode_type m, input idx_type i, input ptr_type r);
      @(negedge clock);
      if (idle_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle_cycles) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, r, i, m};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.push_back(predict_queue_op(m, i, r));
      if (burst_left > 0) begin
         burst_left--;
         idle_cycles = 0;
      end else begin
         burst_left  = $urandom_range(1, 12);
         idle_cycles = (tx_gap_max > 0) ? $urandom_range(1, tx_gap_max) : 0;
      end
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // receiver: long hold-off on request, otherwise runs of ready and stall
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_stall_max == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         if (rx_run == 0) begin
            rx_ready_now = $urandom_range(0, 1);
            rx_run       = $urandom_range(1, rx_stall_max);
         end
         rx_run--;
         rsp_tready <= rx_ready_now;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response beat with none expected, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[0] !== want.found) begin
               $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[7:1] !== want.sender_id) begin
               $display("%0t: sender_id expected %0d actual %0d",
                        $time, want.sender_id, rsp_tdata[7:1]);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_op(MODE_FIND_SEND, 6'd0,  NONE);
      send_op(MODE_FIND_RECV, 6'd0,  NONE);
      send_op(MODE_REMOVE,    6'd0,  NONE);   // not queued: empties
      send_op(MODE_ENQ,       6'd0,  7'd0);
      send_op(MODE_ENQ,       6'd63, NONE);
      send_op(MODE_ENQ,       6'd5,  7'd127); // out of range, stored as none
      send_op(MODE_ENQ,       6'd0,  7'd10);  // already queued: receiver only
      send_op(MODE_ENQ,       6'd20, 7'd63);
      send_op(MODE_FIND_SEND, 6'd20, 7'd0);
      send_op(MODE_FIND_SEND, 6'd0,  7'd0);
      send_op(MODE_FIND_RECV, 6'd10, 7'd0);
      send_op(MODE_FIND_RECV, 6'd63, 7'd0);
      send_op(MODE_FIND_RECV, 6'd0,  7'd0);
      send_op(MODE_REMOVE,    6'd63, 7'd0);   // middle
      send_op(MODE_REMOVE,    6'd0,  7'd0);   // head
      send_op(MODE_REMOVE,    6'd20, 7'd0);   // tail
      send_op(MODE_FIND_SEND, 6'd5,  7'd0);
      send_op(MODE_REMOVE,    6'd5,  7'd0);   // lone entry
      send_op(MODE_FIND_SEND, 6'd5,  7'd0);
      send_op(MODE_ENQ,       6'd7,  7'd64);
      send_op(MODE_ENQ,       6'd42, 7'd21);
      send_op(MODE_REMOVE,    6'd9,  7'd0);   // not queued: empties
      send_op(MODE_FIND_SEND, 6'd42, 7'd0);
      send_op(MODE_FIND_RECV, 6'd21, 7'd0);
   endtask

   task automatic test_full_walk();
      idx_type order [0:NUM_ENTRIES-1];
      idx_type tmp;
      int      j;
      for (int k = 0; k < NUM_ENTRIES; k++) order[k] = idx_type'(k);
      for (int k = NUM_ENTRIES - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      for (int k = 0; k < NUM_ENTRIES; k++)
         send_op(MODE_ENQ, order[k], ptr_type'($urandom_range(0, 40)));
      send_op(MODE_FIND_SEND, mdl_tail[IDX_W-1:0], 7'd0);
      send_op(MODE_FIND_SEND, mdl_head[IDX_W-1:0], 7'd0);
      send_op(MODE_FIND_RECV, 6'd63, 7'd0);
      send_op(MODE_FIND_RECV, idx_type'($urandom_range(0, 40)), 7'd0);
      send_op(MODE_REMOVE, order[31], 7'd0);
      send_op(MODE_FIND_SEND, order[31], 7'd0);
      send_op(MODE_REMOVE, order[31], 7'd0);
      send_op(MODE_FIND_SEND, order[0], 7'd0);
   endtask

   task automatic test_backpressure();
      tx_gap_max = 0;
      hold_len   = 400;
      hold_token++;
      for (int k = 0; k < 30; k++)
         send_op(($urandom_range(0, 1) != 0) ? MODE_ENQ : MODE_FIND_SEND,
                 idx_type'($urandom), pick_receiver());
      wait_for_responses();
   endtask

   task automatic test_random_traffic(input int count);
      int       pct;
      mode_type m;
      idx_type  i;
      ptr_type  r;
      for (int k = 0; k < count; k++) begin
         refresh_live();
         pct = $urandom_range(0, 99);
         i   = idx_type'($urandom);
         r   = pick_receiver();
         if (pct < ((live_ids.size() > 24) ? 10 : 38)) begin
            m = MODE_ENQ;
         end else if (pct < 62) begin
            m = MODE_REMOVE;
            if (live_ids.size() > 0 && pct < 61)
               i = live_ids[$urandom_range(0, live_ids.size() - 1)];
         end else if (pct < 80) begin
            m = MODE_FIND_SEND;
            if (live_ids.size() > 0 && pct < 75)
               i = live_ids[$urandom_range(0, live_ids.size() - 1)];
         end else begin
            m = MODE_FIND_RECV;
            if (live_ids.size() > 0 && pct < 95)
               i = mdl_recv[live_ids[$urandom_range(0, live_ids.size() - 1)]][IDX_W-1:0];
         end
         send_op(m, i, r);
      end
   endtask

   initial begin
      for (int k = 0; k < NUM_ENTRIES; k++) mdl_recv[k] = NONE;
      clear_model_links();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_gap_max   = 0;
      rx_stall_max = 0;
      test_directed();
      tx_gap_max   = 4;
      rx_stall_max = 3;
      test_full_walk();
      test_backpressure();
      tx_gap_max   = 0;
      rx_stall_max = 0;
      test_random_traffic(120);
      wait_for_responses();
      tx_gap_max   = 8;
      rx_stall_max = 6;
      test_random_traffic(120);
      tx_gap_max   = 3;
      rx_stall_max = 0;
      test_random_traffic(120);
      wait_for_responses();
      tx_gap_max   = 0;
      rx_stall_max = 12;
      test_random_traffic(120);

      wait_for_responses();
      repeat (80) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/ilmq_pkg.sv
hw/rtl/ilmq_store.sv
hw/rtl/ilmq_seq.sv
hw/rtl/indexed_linked_message_queue.sv
tb/tb.sv
